FILE: src/bidat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bidat_pkg: shared definitions for the bounded ID admission table
// Sizes, action and result codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package bidat_pkg;

	localparam int CAPACITY = 32;
	localparam int ID_W     = 22;
	localparam int CFG_W    = 6;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(32);

	typedef enum logic [1:0] {
		ACT_CONNECT    = 2'd0,
		ACT_DISCONNECT = 2'd1,
		ACT_SHUTDOWN   = 2'd2,
		ACT_NOP        = 2'd3
	} action_t;

	localparam logic [2:0] KIND_AUTHORIZED    = 3'd0;
	localparam logic [2:0] KIND_REFUSED       = 3'd1;
	localparam logic [2:0] KIND_DISCONNECTED  = 3'd2;
	localparam logic [2:0] KIND_NOT_CONNECTED = 3'd3;
	localparam logic [2:0] KIND_SHUTDOWN      = 3'd4;

	typedef struct packed {
		logic [2:0]       kind;
		logic [CNT_W-1:0] count;
		logic [ID_W-1:0]  id;
		logic             last;
	} rsp_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [ID_W-1:0]  wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic             idle;
		logic [CNT_W-1:0] count;
	} stat_t;

endpackage

`default_nettype wire

FILE: src/bidat_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bidat_if: request and result channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface bidat_req_if;
	import bidat_pkg::*;

	logic            valid;
	logic            ready;
	logic [1:0]      action;
	logic [ID_W-1:0] requester_id;

	modport source (output valid, output action, output requester_id, input ready);
	modport sink   (input valid, input action, input requester_id, output ready);
endinterface

interface bidat_rsp_if;
	import bidat_pkg::*;

	logic             valid;
	logic             ready;
	logic [2:0]       result_kind;
	logic [CNT_W-1:0] entry_count;
	logic [ID_W-1:0]  target_id;
	logic             last;

	modport source (output valid, output result_kind, output entry_count,
		output target_id, output last, input ready);
	modport sink   (input valid, input result_kind, input entry_count,
		input target_id, input last, output ready);
endinterface

`default_nettype wire

FILE: src/bidat_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bidat_store: ID memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bidat_store (
	input  wire logic                      clk,
	input  wire bidat_pkg::mem_req_t       mem_req,
	output logic [bidat_pkg::ID_W-1:0]     rdata_q
);
	import bidat_pkg::*;

	logic [ID_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		rdata_q <= mem[mem_req.raddr];
	end

endmodule

`default_nettype wire

FILE: src/bidat_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bidat_seq: request sequencer
// Walks memory an entry per cycle: search, compaction; shutdown stalls on rsp.
// ----------------------------------------------------------------------------
module bidat_seq (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [bidat_pkg::CNT_W-1:0] eff_cap,
	bidat_req_if.sink                       req,
	bidat_rsp_if.source                     rsp,
	output bidat_pkg::mem_req_t             mem_req,
	input  wire logic [bidat_pkg::ID_W-1:0] rdata_q,
	output bidat_pkg::stat_t                stat
);
	import bidat_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SRCH  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_DUMP  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [ID_W-1:0]  id_q;
	rsp_t             pend_q, pend_d;
	logic             pend_load;
	rsp_t             rsp_q, rsp_d;
	logic             rsp_valid_q;
	logic             out_load;
	logic             out_free;
	logic             accept;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		cnt_d         = cnt_q;
		pend_d        = pend_q;
		pend_load     = 1'b0;
		rsp_d         = pend_q;
		out_load      = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = idx_q[IDX_W-1:0];
		mem_req.wdata = rdata_q;
		mem_req.raddr = idx_q[IDX_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				// entry 0 is primed so a walk can start on the next cycle
				mem_req.raddr = '0;
				if (accept) begin
					idx_d = '0;
					unique case (action_t'(req.action))
						ACT_CONNECT: begin
							pend_load   = 1'b1;
							pend_d.id   = req.requester_id;
							pend_d.last = 1'b1;
							if (cnt_q < eff_cap) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = cnt_q[IDX_W-1:0];
								mem_req.wdata = req.requester_id;
								cnt_d         = cnt_q + CNT_W'(1);
								pend_d.kind   = KIND_AUTHORIZED;
								pend_d.count  = cnt_q + CNT_W'(1);
							end else begin
								pend_d.kind  = KIND_REFUSED;
								pend_d.count = cnt_q;
							end
							state_d = ST_EMIT;
						end
						ACT_DISCONNECT: state_d = ST_SRCH;
						ACT_SHUTDOWN:   state_d = ST_DUMP;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_SRCH: begin
				if (idx_q == cnt_q) begin
					pend_load = 1'b1;
					pend_d    = '{kind: KIND_NOT_CONNECTED, count: cnt_q, id: id_q,
						last: 1'b1};
					state_d   = ST_EMIT;
				end else if (rdata_q == id_q) begin
					mem_req.raddr = IDX_W'(idx_q + CNT_W'(1));
					state_d       = ST_SHIFT;
				end else begin
					idx_d         = idx_q + CNT_W'(1);
					mem_req.raddr = IDX_W'(idx_q + CNT_W'(1));
				end
			end
			ST_SHIFT: begin
				// rdata_q holds entry idx+1 here
				if ((idx_q + CNT_W'(1)) < cnt_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q[IDX_W-1:0];
					mem_req.wdata = rdata_q;
					idx_d         = idx_q + CNT_W'(1);
					mem_req.raddr = IDX_W'(idx_q + CNT_W'(2));
				end else begin
					cnt_d     = cnt_q - CNT_W'(1);
					pend_load = 1'b1;
					pend_d    = '{kind: KIND_DISCONNECTED, count: cnt_q - CNT_W'(1),
						id: id_q, last: 1'b1};
					state_d   = ST_EMIT;
				end
			end
			ST_DUMP: begin
				if (idx_q == cnt_q) begin
					cnt_d     = '0;
					pend_load = 1'b1;
					pend_d    = '{kind: KIND_SHUTDOWN, count: '0, id: '0, last: 1'b1};
					state_d   = ST_EMIT;
				end else if (out_free) begin
					out_load      = 1'b1;
					rsp_d         = '{kind: KIND_SHUTDOWN, count: '0, id: rdata_q,
						last: 1'b0};
					idx_d         = idx_q + CNT_W'(1);
					mem_req.raddr = IDX_W'(idx_q + CNT_W'(1));
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= req.requester_id;
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (out_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_q.kind;
	assign rsp.entry_count = rsp_q.count;
	assign rsp.target_id   = rsp_q.id;
	assign rsp.last        = rsp_q.last;

	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.count = cnt_q;

endmodule

`default_nettype wire

FILE: src/bounded_id_admission_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_id_admission_table: capped, compacting list of requester IDs
// Admits, removes and flushes IDs; one request at a time.
// ----------------------------------------------------------------------------
// Usage
//   req   : valid/ready request channel (action, requester_id). ready is high
//           only while the sequencer is idle.
//   rsp   : valid/ready result channel (result_kind, entry_count, target_id,
//           last). One output register; last marks the final result of a
//           request.
//   cfg   : cfg_we/cfg_wdata write capacity_in_use; write only while idle.
// Steps (N = IDs stored, one memory read port walked one entry per cycle)
//   connect    : result set up, then loaded into the output register.
//   disconnect : search, then (if found) shift-down of later entries.
//   shutdown   : N kill targets at one per cycle while the receiver keeps up,
//                then the closing result.
//   A new request is taken once the previous result is in the output
//   register; that register may still be waiting for the receiver.
// Reset clears the count (table empty) and sets capacity to 32; memory
// contents are not cleared. A stalled receiver holds the output register and
// the sequencer waits, so nothing is lost.
// ----------------------------------------------------------------------------
module bounded_id_admission_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bidat_req_if.sink                        req,
	bidat_rsp_if.source                      rsp,
	input  wire logic                        cfg_we,
	input  wire logic [bidat_pkg::CFG_W-1:0] cfg_wdata
);
	import bidat_pkg::*;

	logic [CFG_W-1:0] cap_q;
	logic [CNT_W-1:0] eff_cap;
	mem_req_t         mem_req;
	logic [ID_W-1:0]  rdata_q;
	stat_t            stat;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// a capacity above the table depth acts as the depth
	assign eff_cap = (cap_q > CFG_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cap_q);

	// sequencer: search, compaction and shutdown walks
	bidat_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.eff_cap (eff_cap),
		.req     (req),
		.rsp     (rsp),
		.mem_req (mem_req),
		.rdata_q (rdata_q),
		.stat    (stat)
	);

	// ID memory
	bidat_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata_q (rdata_q)
	);

`ifndef SYNTHESIS
	// count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(CAPACITY))
		else $error("stored count above table depth");

	// a refused connect leaves the count alone
	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.action == ACT_CONNECT && stat.count >= eff_cap
		|=> stat.count == $past(stat.count))
		else $error("count changed on a refused connect");

	// a real request leaves the block busy in the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.action != ACT_NOP |=> !req.ready)
		else $error("request taken while previous one in progress");

	// while the closing shutdown result waits and no new request has started,
	// the table stays empty
	a_close_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.last && rsp.result_kind == KIND_SHUTDOWN && stat.idle
		|-> stat.count == '0)
		else $error("table not empty after shutdown");
`endif

endmodule

`default_nettype wire
